/* rtl/tbp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbp_pkg: shared types and constants of the token bucket policer
// Holds the word formats of both channels, the table entry layout, the
// register map and the configuration defaults.
// ----------------------------------------------------------------------------
package tbp_pkg;

  // Table geometry (a power of two).
  localparam int ENTRIES = 65536;
  localparam int IDX_W   = $clog2(ENTRIES);

  // Field widths.
  localparam int IN_IDX_W = 16;
  localparam int TIME_W   = 64;
  localparam int TOK_W    = 16;
  localparam int PER_W    = 32;
  localparam int IRST_W   = 36;

  // Divider widths: the dividend is an idle time below the idle reset value.
  localparam int DIV_W   = IRST_W;
  localparam int DCNT_W  = $clog2(DIV_W + 1);

  // Register map (index is paddr[4:3]).
  localparam int ADDR_W = 5;
  localparam logic [1:0] REG_PERIOD = 2'd0;
  localparam logic [1:0] REG_BURST  = 2'd1;
  localparam logic [1:0] REG_IDLE   = 2'd2;

  // Configuration defaults.
  localparam logic [PER_W-1:0]  DEF_PERIOD   = PER_W'(1000000);
  localparam logic [TOK_W-1:0]  DEF_CAPACITY = TOK_W'(100);
  localparam logic [IRST_W-1:0] DEF_IDLE     = IRST_W'(64'd5000000000);

  typedef struct packed {
    logic [IN_IDX_W-1:0] entry_index;
    logic                is_udp;
    logic [TIME_W-1:0]   now_ns;
  } tbp_in_t;

  typedef struct packed {
    logic             drop;
    logic [TOK_W-1:0] tokens_left;
  } tbp_out_t;

  typedef struct packed {
    logic              valid;
    logic [TIME_W-1:0] seen;
    logic [TOK_W-1:0]  tokens;
  } tbp_ent_t;

  // Reduce an entry index modulo the table depth.
  function automatic logic [IDX_W-1:0] slot_of(input logic [IN_IDX_W-1:0] e);
    logic [IDX_W+IN_IDX_W-1:0] wide;
    wide = {{IDX_W{1'b0}}, e};
    return wide[IDX_W-1:0];
  endfunction

endpackage

/* rtl/tbp_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbp_div: iterative restoring divider
// Produces one quotient bit per cycle; done pulses when the quotient is ready.
// ----------------------------------------------------------------------------
module tbp_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [tbp_pkg::DIV_W-1:0]   dividend,
  input  logic [tbp_pkg::PER_W-1:0]   divisor,
  output logic                        done,
  output logic [tbp_pkg::DIV_W-1:0]   quotient
);
  import tbp_pkg::*;

  logic              busy;
  logic [DCNT_W-1:0] cnt;
  logic [PER_W-1:0]  rem;
  logic [DIV_W-1:0]  dvd;
  logic [PER_W:0]    trial;
  logic              fits;

  // Shift in the next dividend bit and test it against the divisor.
  assign trial = {rem, dvd[DIV_W-1]};
  assign fits  = trial >= {1'b0, divisor};

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DCNT_W'(DIV_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == DCNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dvd      <= dividend;
      quotient <= '0;
    end else if (busy) begin
      rem      <= fits ? PER_W'(trial - {1'b0, divisor}) : trial[PER_W-1:0];
      dvd      <= {dvd[DIV_W-2:0], 1'b0};
      quotient <= {quotient[DIV_W-2:0], fits};
    end
  end

endmodule

/* rtl/tbp_table.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbp_table: bucket state memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tbp_table (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [tbp_pkg::IDX_W-1:0] wr_addr,
  input  tbp_pkg::tbp_ent_t         wr_data,
  input  logic                      rd_en,
  input  logic [tbp_pkg::IDX_W-1:0] rd_addr,
  output tbp_pkg::tbp_ent_t         rd_data
);
  import tbp_pkg::*;

  tbp_ent_t mem [ENTRIES];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/per_entry_token_bucket_policer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_entry_token_bucket_policer: token bucket per source entry
// Each input word is one packet event; each output word says whether to drop
// it and how many tokens the entry keeps.
// ----------------------------------------------------------------------------
// Usage:
// The input channel carries entry index, UDP flag and a nanosecond timestamp;
// the output channel returns one word per input word, in order. Both use
// valid/stall. Registers are to be written over the APB port only while the
// block is idle; the block itself does not enforce this. The refill period
// is at 0x00, burst at 0x08, idle reset time at 0x10. From acceptance to
// output valid an event passes through a table read, the idle time
// subtraction and compare, the bit-serial divider (idle time over refill
// period) and the level update with table write. When the idle time reaches
// the idle reset value the divider is skipped. The next word is accepted once
// the previous one has been written back, even while its result still waits
// in the output register.
// After reset the block sweeps the table once to clear the valid bits of every
// entry, one entry per cycle; input is stalled during the sweep, register
// writes are taken. A stalled output holds its word; the block takes the
// current event up to the write-back and waits for the output to be free.
// ----------------------------------------------------------------------------
module per_entry_token_bucket_policer (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  tbp_pkg::tbp_in_t             in_word,
  output logic                         out_valid,
  input  logic                         out_stall,
  output tbp_pkg::tbp_out_t            out_word,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tbp_pkg::ADDR_W-1:0]   paddr,
  input  logic [63:0]                  pwdata,
  output logic [63:0]                  prdata,
  output logic                         pready
);
  import tbp_pkg::*;

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_READ   = 3'd2;
  localparam logic [2:0] S_CALC   = 3'd3;
  localparam logic [2:0] S_CMP    = 3'd4;
  localparam logic [2:0] S_DIV    = 3'd5;
  localparam logic [2:0] S_LEVEL  = 3'd6;
  localparam logic [2:0] S_FINISH = 3'd7;

  logic [2:0]        state;
  logic [IDX_W-1:0]  clr_cnt;

  logic [PER_W-1:0]  cfg_period;
  logic [TOK_W-1:0]  cfg_burst;
  logic [IRST_W-1:0] cfg_idle;
  logic [PER_W-1:0]  period;
  logic [TOK_W-1:0]  burst;

  tbp_in_t           item;
  logic [IDX_W-1:0]  slot;
  logic [TIME_W-1:0] idle;
  logic [TOK_W-1:0]  tokens;
  logic              full;
  logic [TOK_W-1:0]  level;

  logic              tbl_wr_en;
  logic [IDX_W-1:0]  tbl_wr_addr;
  tbp_ent_t          tbl_wr_data;
  tbp_ent_t          tbl_rd_data;

  logic              div_start;
  logic              div_done;
  logic [DIV_W-1:0]  quotient;

  logic [TOK_W:0]    sum;
  logic              out_free;
  logic              has;
  logic              cfg_wr;

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_period <= DEF_PERIOD;
      cfg_burst  <= DEF_CAPACITY;
      cfg_idle   <= DEF_IDLE;
    end else if (cfg_wr) begin
      case (paddr[4:3])
        REG_PERIOD: cfg_period <= pwdata[PER_W-1:0];
        REG_BURST:  cfg_burst  <= pwdata[TOK_W-1:0];
        REG_IDLE:   cfg_idle   <= pwdata[IRST_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:3])
      REG_PERIOD: prdata = {{(64-PER_W){1'b0}}, cfg_period};
      REG_BURST:  prdata = {{(64-TOK_W){1'b0}}, cfg_burst};
      REG_IDLE:   prdata = {{(64-IRST_W){1'b0}}, cfg_idle};
      default:    prdata = '0;
    endcase
  end

  // Zero period and burst values fall back to the defaults.
  assign period = (cfg_period == '0) ? DEF_PERIOD : cfg_period;
  assign burst  = (cfg_burst == '0) ? DEF_CAPACITY : cfg_burst;

  assign in_stall = (state != S_IDLE);
  assign slot     = slot_of(item.entry_index);
  assign out_free = !out_valid || !out_stall;
  assign has      = (level != '0);

  // Idle reset test; idle holds its value from the compare state onward.
  assign full = idle >= {{(TIME_W-IRST_W){1'b0}}, cfg_idle};

  // Capped refill: a gain of a full burst or more saturates.
  assign sum = {1'b0, tokens} + {1'b0, quotient[TOK_W-1:0]};

  // Table ports: the clearing sweep and the write-back share the write port.
  assign tbl_wr_en   = (state == S_CLEAR) || (state == S_FINISH && out_free);
  assign tbl_wr_addr = (state == S_CLEAR) ? clr_cnt : slot;
  always_comb begin
    tbl_wr_data = '0;
    if (state != S_CLEAR) begin
      tbl_wr_data.valid  = 1'b1;
      tbl_wr_data.seen   = item.now_ns;
      tbl_wr_data.tokens = level - TOK_W'(has);
    end
  end

  assign div_start = (state == S_CMP) && !full;

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      // Output register: load a finished word, or empty it once taken.
      if (state == S_FINISH && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == {IDX_W{1'b1}}) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            state <= S_READ;
          end
        end
        S_READ:  state <= S_CALC;
        S_CALC:  state <= S_CMP;
        S_CMP:   state <= full ? S_LEVEL : S_DIV;
        S_DIV: begin
          if (div_done) begin
            state <= S_LEVEL;
          end
        end
        S_LEVEL: state <= S_FINISH;
        S_FINISH: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Event datapath.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          item <= in_word;
        end
      end
      S_CALC: begin
        // An unused entry starts full, as if it was last seen right now.
        if (tbl_rd_data.valid) begin
          idle   <= item.now_ns - tbl_rd_data.seen;
          tokens <= tbl_rd_data.tokens;
        end else begin
          idle   <= '0;
          tokens <= burst;
        end
      end
      S_LEVEL: begin
        if (full || quotient >= {{(DIV_W-TOK_W){1'b0}}, burst} ||
            sum > {1'b0, burst}) begin
          level <= burst;
        end else begin
          level <= sum[TOK_W-1:0];
        end
      end
      S_FINISH: begin
        if (out_free) begin
          out_word.drop        <= !has && item.is_udp;
          out_word.tokens_left <= level - TOK_W'(has);
        end
      end
      default: ;
    endcase
  end

  tbp_table u_table (
    .clk     (clk),
    .wr_en   (tbl_wr_en),
    .wr_addr (tbl_wr_addr),
    .wr_data (tbl_wr_data),
    .rd_en   (state == S_READ),
    .rd_addr (slot),
    .rd_data (tbl_rd_data)
  );

  tbp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (idle[DIV_W-1:0]),
    .divisor  (period),
    .done     (div_done),
    .quotient (quotient)
  );

endmodule

/* rtl/tbp_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbp_checker: port-level assertions for the policer
// Watches the channels of the top level and is bound to it.
// ----------------------------------------------------------------------------
module tbp_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_stall,
  input tbp_pkg::tbp_in_t           in_word,
  input logic                       out_valid,
  input logic                       out_stall,
  input tbp_pkg::tbp_out_t          out_word
);
  import tbp_pkg::*;

  // A stalled output word stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("output word changed while stalled");

  // One event at a time: the block is busy right after taking a word.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted on consecutive cycles");

  // Reset empties the output register.
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

  // A drop only happens with an empty bucket.
  a_drop: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.drop |-> out_word.tokens_left == '0)
    else $error("drop with tokens left");

endmodule

bind per_entry_token_bucket_policer tbp_checker u_tbp_checker (.*);
